// File: src/ile_pkg.sv
package ile_pkg;

  // Field widths of the request and result transactions
  localparam int OP_W    = 3;
  localparam int IDX_W   = 10;
  localparam int WORD_W  = 64;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 11;
  localparam int CNT_O_W = 11;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic [STAT_W-1:0]         status_t;
  typedef logic signed [FOUND_W-1:0] found_t;
  typedef logic [CNT_O_W-1:0]        count_t;

  // Operation codes
  localparam op_t OP_GET    = 3'd0;
  localparam op_t OP_SET    = 3'd1;
  localparam op_t OP_APPEND = 3'd2;
  localparam op_t OP_REMOVE = 3'd3;
  localparam op_t OP_CLEAR  = 3'd4;
  localparam op_t OP_FIND   = 3'd5;

  // Status codes
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_OOB  = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  // Found index when the key is absent
  localparam found_t NOT_FOUND = '1;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;       // capture request fields
    logic    rd_idx;     // read entry at request index
    logic    wr_idx;     // write value at request index
    logic    wr_app;     // write value at count, count + 1
    logic    clr_cnt;    // count to zero
    logic    dec_cnt;    // count - 1
    logic    scan_rm;    // scan pointer to index + 1
    logic    scan_find;  // scan pointer to zero
    logic    scan_step;  // read at pointer if below count
    logic    shift_wr;   // write last read word one slot down
    logic    found_cap;  // record last read address as match
    logic    res_load;   // load result register
    status_t status;     // status for the result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic idx_ok;     // index below count
    logic not_full;   // count below capacity
    logic scan_more;  // scan pointer below count
    logic pend;       // read data from last scan step is valid
    logic hit;        // pending read data equals key
  } stat_t;

endpackage

// File: src/ile_in_if.sv
interface ile_in_if;
  logic           valid;
  logic           ready;
  ile_pkg::op_t   op;
  ile_pkg::idx_t  index;
  ile_pkg::word_t value;
  ile_pkg::word_t key;

  modport source (output valid, output op, output index, output value, output key,
                  input ready);
  modport sink   (input valid, input op, input index, input value, input key,
                  output ready);
endinterface

// File: src/ile_out_if.sv
interface ile_out_if;
  logic              valid;
  logic              ready;
  ile_pkg::status_t  status;
  ile_pkg::word_t    read_value;
  ile_pkg::found_t   found_index;
  ile_pkg::count_t   count;

  modport source (output valid, output status, output read_value, output found_index,
                  output count, input ready);
  modport sink   (input valid, input status, input read_value, input found_index,
                  input count, output ready);
endinterface

// File: src/ile_ctrl.sv
module ile_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  ile_pkg::stat_t stat,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  output ile_pkg::cmd_t  cmd
);
  import ile_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FIN    = 2'd3;

  logic [1:0] state_r, state_nxt;
  status_t    st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command decode
  always_comb begin
    cmd           = '0;
    cmd.status    = st_r;
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt    = ST_OK;
        state_nxt = S_FIN;
        case (stat.op)
          OP_GET: begin
            if (stat.idx_ok) cmd.rd_idx = 1'b1;
            else st_nxt = ST_OOB;
          end
          OP_SET: begin
            if (stat.idx_ok) cmd.wr_idx = 1'b1;
            else st_nxt = ST_OOB;
          end
          OP_APPEND: begin
            if (stat.not_full) cmd.wr_app = 1'b1;
            else st_nxt = ST_FULL;
          end
          OP_REMOVE: begin
            if (stat.idx_ok) begin
              cmd.scan_rm = 1'b1;
              state_nxt   = S_SCAN;
            end else begin
              st_nxt = ST_OOB;
            end
          end
          OP_CLEAR: cmd.clr_cnt = 1'b1;
          OP_FIND: begin
            cmd.scan_find = 1'b1;
            state_nxt     = S_SCAN;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (stat.op == OP_FIND && stat.hit) begin
          cmd.found_cap = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          // remove: move the word read last cycle down by one
          if (stat.op == OP_REMOVE && stat.pend) cmd.shift_wr = 1'b1;
          if (!stat.pend && !stat.scan_more) begin
            if (stat.op == OP_REMOVE) cmd.dec_cnt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/ile_dpath.sv
module ile_dpath #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ile_pkg::cmd_t     cmd,
  output ile_pkg::stat_t    stat,
  input  ile_pkg::op_t      in_op,
  input  ile_pkg::idx_t     in_index,
  input  ile_pkg::word_t    in_value,
  input  ile_pkg::word_t    in_key,
  output ile_pkg::status_t  out_status,
  output ile_pkg::word_t    out_read_value,
  output ile_pkg::found_t   out_found_index,
  output ile_pkg::count_t   out_count
);
  import ile_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Entry storage: one write and one registered read per cycle
  word_t mem [CAPACITY];

  op_t               op_r;
  idx_t              idx_r;
  word_t             value_r, key_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] la_r, la_nxt;
  logic              pend_r, pend_nxt;
  found_t            found_r;
  word_t             rdata_r;
  status_t           status_r;
  word_t             read_value_r;
  found_t            found_index_r;
  count_t            count_out_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  word_t             wr_data;
  logic              scan_more;

  assign scan_more = (ptr_r < count_r);

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ADDR_W'(idx_r);
    if (cmd.rd_idx) begin
      rd_en = 1'b1;
    end else if (cmd.scan_step && scan_more) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(ptr_r);
    end
    wr_en   = cmd.wr_idx || cmd.wr_app || cmd.shift_wr;
    wr_addr = ADDR_W'(idx_r);
    wr_data = value_r;
    if (cmd.wr_app) begin
      wr_addr = ADDR_W'(count_r);
    end else if (cmd.shift_wr) begin
      wr_addr = la_r - ADDR_W'(1);
      wr_data = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Count and scan pointer
  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_app) count_nxt = count_r + CNT_W'(1);
    else if (cmd.clr_cnt) count_nxt = '0;
    else if (cmd.dec_cnt) count_nxt = count_r - CNT_W'(1);

    ptr_nxt  = ptr_r;
    la_nxt   = la_r;
    pend_nxt = pend_r;
    if (cmd.scan_rm) begin
      ptr_nxt  = CNT_W'(idx_r) + CNT_W'(1);
      pend_nxt = 1'b0;
    end else if (cmd.scan_find) begin
      ptr_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      pend_nxt = scan_more;
      if (scan_more) begin
        ptr_nxt = ptr_r + CNT_W'(1);
        la_nxt  = ADDR_W'(ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    la_r  <= la_nxt;
  end

  // Request capture and match record
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      idx_r   <= in_index;
      value_r <= in_value;
      key_r   <= in_key;
      found_r <= NOT_FOUND;
    end else if (cmd.found_cap) begin
      found_r <= FOUND_W'(la_r);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status_r      <= cmd.status;
      read_value_r  <= (op_r == OP_GET && cmd.status == ST_OK) ? rdata_r : '0;
      found_index_r <= found_r;
      count_out_r   <= CNT_O_W'(count_r);
    end
  end

  assign stat.op        = op_r;
  assign stat.idx_ok    = (CMP_W'(idx_r) < CMP_W'(count_r));
  assign stat.not_full  = (count_r < CNT_W'(CAPACITY));
  assign stat.scan_more = scan_more;
  assign stat.pend      = pend_r;
  assign stat.hit       = pend_r && (rdata_r == key_r);

  assign out_status      = status_r;
  assign out_read_value  = read_value_r;
  assign out_found_index = found_index_r;
  assign out_count       = count_out_r;

endmodule

// File: src/indexed_list_engine.sv
// Fixed-capacity list of signed 64-bit words with one operation per request.
// in_ch (sink): op, index, value, key; a transaction completes on valid && ready.
// out_ch (source): status, read_value, found_index, count; one result per request.
// Only one request is in flight: in_ch.ready is high while the controller idles.
// Get, set, append, clear and unknown ops pass through the decode and finish
// states; the finish state loads the result register and returns to idle,
// where the next request is accepted.
// Remove walks the entries above index through the memory's read and write
// ports, one read and one write per cycle, moving each entry down one slot.
// Find reads one entry per cycle from index 0 and stops at the first match.
// The result sits in an output register; a new request is accepted while it
// waits, and that request holds in its last state until out_ch.ready frees
// the register.
// Reset clears the count, pend flag and controller state; stored words are not
// cleared and no clearing pass is needed since only entries below count are read.
module indexed_list_engine #(
  parameter int CAPACITY = 1024
) (
  input logic      clk,
  input logic      rst_n,
  ile_in_if.sink   in_ch,
  ile_out_if.source out_ch
);
  import ile_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  ile_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_ch.op),
    .in_index        (in_ch.index),
    .in_value        (in_ch.value),
    .in_key          (in_ch.key),
    .out_status      (out_ch.status),
    .out_read_value  (out_ch.read_value),
    .out_found_index (out_ch.found_index),
    .out_count       (out_ch.count)
  );

endmodule
